### rtl/sorted_priority_packet_queue_macros.svh
// Assertion macros for the sorted priority packet queue.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SORTED_PRIORITY_PACKET_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_PACKET_QUEUE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("spq assertion failed: invariant");

// The consequence holds in the cycle after the trigger.
`define SPQ_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("spq assertion failed: next-cycle check");

`endif

### rtl/spq_pkg.sv
// Types, constants and the key order of the sorted priority packet queue.
// No dependencies; used by the interfaces, the cell and the top level.
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

  // True when entry a must be served before entry b.
  function automatic logic key_before(spq_entry_t a, spq_entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = (a.prio < b.prio);
    end else begin
      res = (a.id <= b.id);
    end
    return res;
  endfunction

endpackage

### rtl/spq_in_if.sv
// Input channel of the sorted priority packet queue: valid, ready and request payload.
// Depends on spq_pkg.
interface spq_in_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ID_W-1:0]   packet_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, output opcode, output packet_id, output priority_req,
                  input ready);
  modport sink (input valid, input opcode, input packet_id, input priority_req,
                output ready);
endinterface

### rtl/spq_out_if.sv
// Result channel of the sorted priority packet queue: valid, ready and result payload.
// Depends on spq_pkg.
interface spq_out_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ID_W-1:0]   out_packet_id;
  logic [PRIO_W-1:0] out_priority;

  modport source (output valid, output status, output out_packet_id, output out_priority,
                  input ready);
  modport sink (input valid, input status, input out_packet_id, input out_priority,
                output ready);
endinterface

### rtl/spq_cell.sv
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_ctrl_t  ctrl_i,
  input  spq_pkg::spq_entry_t new_i,
  input  spq_pkg::spq_entry_t left_i,
  input  spq_pkg::spq_entry_t right_i,
  input  logic              occ_i,
  input  logic              before_left_i,
  output logic              before_o,
  output spq_pkg::spq_entry_t entry_o
);
  import spq_pkg::*;

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  assign before_o = !occ_i || key_before(new_i, entry_r);
  assign entry_o  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl_i.rem) begin
      entry_nxt = right_i;
    end else if (ctrl_i.ins) begin
      if (before_left_i) begin
        entry_nxt = left_i;
      end else if (before_o) begin
        entry_nxt = new_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end
endmodule

### rtl/sorted_priority_packet_queue.sv
// Sorted priority packet queue: a chain of CAPACITY cells kept in ascending key order.
// Each transaction's result is registered and appears in the output in the cycle after it.
// Throughput: one insert or remove per cycle unless the result channel stalls; every cell
// compares against the new key and shifts in the same cycle; the output register holds the result.
// Reset clears the entry count and the output valid; cell contents are left as they are.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_cell and the macros header.
`include "sorted_priority_packet_queue_macros.svh"

module sorted_priority_packet_queue (
  input logic       clk,
  input logic       rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               out_valid_r;
  spq_status_t        out_status_r;
  spq_status_t        out_status_nxt;
  spq_entry_t         out_entry_r;
  spq_entry_t         out_entry_nxt;

  logic               accept;
  logic               full;
  logic               empty;
  spq_ctrl_t          ctrl;
  spq_entry_t         new_entry;
  spq_entry_t         cells [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] ahead;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == COUNT_W'(CAPACITY));
  assign empty       = (count_r == '0);
  assign ctrl.ins    = accept && (in_ch.opcode == OP_INSERT) && !full;
  assign ctrl.rem    = accept && (in_ch.opcode == OP_REMOVE) && !empty;
  assign new_entry.id   = in_ch.packet_id;
  assign new_entry.prio = in_ch.priority_req;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (count_r > COUNT_W'(i));
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk          (clk),
        .ctrl_i       (ctrl),
        .new_i        (new_entry),
        .left_i       (new_entry),
        .right_i      (cells[1]),
        .occ_i        (occ[0]),
        .before_left_i(1'b0),
        .before_o     (ahead[0]),
        .entry_o      (cells[0])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      spq_cell u_cell (
        .clk          (clk),
        .ctrl_i       (ctrl),
        .new_i        (new_entry),
        .left_i       (cells[i-1]),
        .right_i      (cells[i]),
        .occ_i        (occ[i]),
        .before_left_i(ahead[i-1]),
        .before_o     (ahead[i]),
        .entry_o      (cells[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk          (clk),
        .ctrl_i       (ctrl),
        .new_i        (new_entry),
        .left_i       (cells[i-1]),
        .right_i      (cells[i+1]),
        .occ_i        (occ[i]),
        .before_left_i(ahead[i-1]),
        .before_o     (ahead[i]),
        .entry_o      (cells[i])
      );
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  always_comb begin
    out_entry_nxt  = '0;
    out_status_nxt = ST_OK;
    if (in_ch.opcode == OP_INSERT) begin
      if (full) begin
        out_status_nxt = ST_FULL;
      end
    end else if (empty) begin
      out_status_nxt = ST_EMPTY;
    end else begin
      out_entry_nxt = cells[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= out_status_nxt;
      out_entry_r  <= out_entry_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.out_packet_id = out_entry_r.id;
  assign out_ch.out_priority  = out_entry_r.prio;

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= COUNT_W'(CAPACITY))
  `SPQ_ASSERT_ALWAYS(a_head_sorted, !occ[1] || key_before(cells[0], cells[1]))
  `SPQ_ASSERT_NEXT(a_remove_ok, ctrl.rem, (count_r == $past(count_r) - COUNT_W'(1)) && (out_status_r == ST_OK))
  `SPQ_ASSERT_NEXT(a_insert_full, accept && (in_ch.opcode == OP_INSERT) && full, $stable(count_r) && (out_status_r == ST_FULL))
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for the sorted priority packet queue: directed and random inserts and removes,
// checked against a sorted software copy of the buffer held in a small scoreboard class.
// Depends on spq_pkg, spq_in_if, spq_out_if and sorted_priority_packet_queue.
module tb;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    spq_status_t       status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } queue_result_t;

  class priority_order_tracker;
    spq_entry_t    held[$];
    queue_result_t pending_results[$];
    int            mismatch_count;

    function void note_request(spq_opcode_t op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
      queue_result_t res;
      spq_entry_t    fresh;
      int            slot;
      res = '{ST_OK, '0, '0};
      if (op == OP_INSERT) begin
        if (held.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          fresh.id   = id;
          fresh.prio = prio;
          slot = 0;
          // A packet goes ahead of the first stored one whose key is not below its own.
          while (slot < held.size() &&
                 !({fresh.prio, fresh.id} <= {held[slot].prio, held[slot].id})) begin
            slot++;
          end
          held.insert(slot, fresh);
        end
      end else if (held.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.id   = held[0].id;
        res.prio = held[0].prio;
        void'(held.pop_front());
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d, id %0h, priority %0h",
               status, id, prio);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatch_count++;
      end
      if (id !== want.id) begin
        $error("out_packet_id: expected %0h, actual %0h", want.id, id);
        mismatch_count++;
      end
      if (prio !== want.prio) begin
        $error("out_priority: expected %0h, actual %0h", want.prio, prio);
        mismatch_count++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off_reqs;
  int   items_sent;
  int   cycle_count;

  priority_order_tracker tracker = new();

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_packet_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_priority_packet_queue] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_request(spq_opcode_t'(in_ch.opcode), in_ch.packet_id, in_ch.priority_req);
      end
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_result(out_ch.status, out_ch.out_packet_id, out_ch.out_priority);
      end
    end
  end

  // The receiver honors a requested hold-off before going back to random stalls.
  initial begin
    int hold_left;
    int seen_reqs;
    hold_left    = 0;
    seen_reqs    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_reqs != seen_reqs) begin
        seen_reqs = hold_off_reqs;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input spq_opcode_t op, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.packet_id    <= id;
    in_ch.priority_req <= prio;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_burst(input int insert_pct, input int len);
    spq_opcode_t       op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    for (int n = 0; n < len; n++) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      case ($urandom_range(0, 3))
        0: begin
          id   = ID_W'($urandom);
          prio = PRIO_W'($urandom);
        end
        1: begin
          id   = ID_W'($urandom);
          prio = PRIO_W'($urandom_range(0, 3));
        end
        2: begin
          id   = ID_W'($urandom_range(0, 7));
          prio = PRIO_W'($urandom_range(0, 3));
        end
        default: begin
          id   = $urandom_range(0, 1) ? '1 : '0;
          prio = $urandom_range(0, 1) ? '1 : '0;
        end
      endcase
      send_item(op, id, prio);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    int phase_target;
    int kind;
    send_pcts = '{0, 55, 0, 33};
    recv_pcts = '{0, 0, 55, 33};
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_INSERT;
    in_ch.packet_id    = '0;
    in_ch.priority_req = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_off_reqs      = 0;
    items_sent         = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(OP_REMOVE, '0, '0);
    send_item(OP_INSERT, 16'hFFFF, 8'hFF);
    send_item(OP_INSERT, 16'h0000, 8'h00);
    send_item(OP_INSERT, 16'hFFFF, 8'h00);
    send_item(OP_INSERT, 16'h0000, 8'hFF);
    send_item(OP_INSERT, 16'h1234, 8'h80);
    send_item(OP_INSERT, 16'h1234, 8'h80);
    send_item(OP_INSERT, 16'h1233, 8'h80);
    send_item(OP_INSERT, 16'h1235, 8'h80);
    send_item(OP_INSERT, 16'h0001, 8'h7F);
    send_item(OP_INSERT, 16'hAAAA, 8'h55);
    send_item(OP_INSERT, 16'h5555, 8'hAA);
    repeat (12) send_item(OP_REMOVE, '0, '0);
    wait_drained();

    // Fill past capacity so that inserts are refused, then drain past empty.
    send_burst(100, CAPACITY + 3);
    send_burst(0, CAPACITY + 2);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      phase_target   = items_sent + 70;
      while (items_sent < phase_target) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          send_burst(90, $urandom_range(4, CAPACITY + 4));
        end else if (kind < 7) begin
          send_burst(10, $urandom_range(4, CAPACITY + 4));
        end else begin
          send_burst(50, $urandom_range(1, 30));
        end
      end
      wait_drained();
    end

    // The receiver holds off while the sender keeps offering, so the input backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_reqs++;
    send_burst(60, 40);
    wait_drained();

    repeat (20) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
      $display("[sorted_priority_packet_queue] OK");
    end else begin
      $display("[sorted_priority_packet_queue] ERROR");
    end
    $finish;
  end
endmodule
